// File: hw/rtl/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and codes for the CSV field tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cft_pkg;

    localparam int unsigned MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_EMPTY      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PLAIN      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PLAIN_ESC  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QUOTED     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUOTED_ESC = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLOSED     = 3'd5;

    localparam logic [1:0] KIND_CONTENT    = 2'd0;
    localparam logic [1:0] KIND_FIELD_END  = 2'd1;
    localparam logic [1:0] KIND_RECORD_END = 2'd2;
    localparam logic [1:0] KIND_ERROR      = 2'd3;

    localparam logic [1:0] ERR_BACKSLASH = 2'd0;
    localparam logic [1:0] ERR_TEXT      = 2'd1;
    localparam logic [1:0] ERR_QUOTE     = 2'd2;
    localparam logic [1:0] ERR_COUNT     = 2'd3;

    localparam logic [7:0] CHR_COMMA     = 8'h2C;
    localparam logic [7:0] CHR_QUOTE     = 8'h22;
    localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHR_SPACE     = 8'h20;

    localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              header_pending;
        logic [7:0]        header_fields;
        logic [7:0]        field_count;
        logic [31:0]       newlines_seen;
        logic              halted;
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  content_byte;
        logic [7:0]  field_number;
        logic        is_header;
        logic [31:0] line_number;
        logic [1:0]  error_code;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/cft_step.sv
// ----------------------------------------------------------------------------
// cft_step
// Next-state and result logic for one byte of CSV text.
// ----------------------------------------------------------------------------
`default_nettype none

module cft_step
    import cft_pkg::*;
#(
    parameter int unsigned FIELD_CAP = 255
) (
    input  wire t_state     i_state,
    input  wire logic [7:0] i_byte,
    output t_state          o_state,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam logic [7:0] CAP = 8'(FIELD_CAP);

    logic [MODE_W-1:0] w_mode;
    logic              w_nl;
    logic              w_sep;
    logic              w_inq;
    logic [31:0]       w_line;
    logic [7:0]        w_count;

    always_comb begin
        w_mode  = (i_state.mode > MODE_CLOSED) ? MODE_EMPTY : i_state.mode;
        w_nl    = (i_byte == CHR_NEWLINE);
        w_sep   = w_nl || (i_byte == CHR_COMMA);
        w_inq   = (w_mode == MODE_QUOTED) || (w_mode == MODE_QUOTED_ESC);
        w_line  = (i_state.newlines_seen == LINE_MAX) ? LINE_MAX
                                                      : i_state.newlines_seen + 32'd1;
        w_count = (i_state.field_count >= CAP) ? CAP : i_state.field_count + 8'd1;

        o_state                  = i_state;
        o_res_valid              = 1'b0;
        o_res.kind               = KIND_CONTENT;
        o_res.content_byte       = 8'd0;
        o_res.field_number       = i_state.field_count;
        o_res.is_header          = i_state.header_pending;
        o_res.line_number        = w_line;
        o_res.error_code         = ERR_BACKSLASH;

        if (!i_state.halted && !(i_byte < CHR_SPACE && !w_nl)) begin
            if (w_nl && i_state.newlines_seen != LINE_MAX) begin
                o_state.newlines_seen = i_state.newlines_seen + 32'd1;
            end
            o_state.mode = w_mode;
            if (w_mode == MODE_CLOSED && !w_sep) begin
                o_state.halted = 1'b1;
                o_res_valid    = 1'b1;
                o_res.kind     = KIND_ERROR;
                if (i_byte == CHR_BACKSLASH) begin
                    o_res.error_code = ERR_BACKSLASH;
                end else if (i_byte == CHR_QUOTE) begin
                    o_res.error_code = ERR_QUOTE;
                end else begin
                    o_res.error_code = ERR_TEXT;
                end
            end else if (w_mode == MODE_PLAIN_ESC || w_mode == MODE_QUOTED_ESC) begin
                o_state.mode       = (w_mode == MODE_PLAIN_ESC) ? MODE_PLAIN : MODE_QUOTED;
                o_res_valid        = 1'b1;
                o_res.content_byte = i_byte;
            end else if (i_byte == CHR_BACKSLASH) begin
                o_state.mode = w_inq ? MODE_QUOTED_ESC : MODE_PLAIN_ESC;
            end else if (i_byte == CHR_QUOTE) begin
                if (w_mode == MODE_EMPTY) begin
                    o_state.mode = MODE_QUOTED;
                end else if (w_mode == MODE_QUOTED) begin
                    o_state.mode = MODE_CLOSED;
                end else begin
                    o_state.mode       = MODE_PLAIN;
                    o_res_valid        = 1'b1;
                    o_res.content_byte = i_byte;
                end
            end else if (w_sep && !w_inq) begin
                o_state.mode = MODE_EMPTY;
                o_res_valid  = 1'b1;
                if (!w_nl) begin
                    o_state.field_count = w_count;
                    o_res.kind          = KIND_FIELD_END;
                end else if (i_state.header_pending) begin
                    o_state.header_fields  = w_count;
                    o_state.header_pending = 1'b0;
                    o_state.field_count    = 8'd0;
                    o_res.kind             = KIND_RECORD_END;
                end else if (w_count != i_state.header_fields) begin
                    o_state.halted      = 1'b1;
                    o_state.field_count = w_count;
                    o_res.kind          = KIND_ERROR;
                    o_res.error_code    = ERR_COUNT;
                end else begin
                    o_state.field_count = 8'd0;
                    o_res.kind          = KIND_RECORD_END;
                end
            end else begin
                o_state.mode       = w_inq ? MODE_QUOTED : MODE_PLAIN;
                o_res_valid        = 1'b1;
                o_res.content_byte = i_byte;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cft_out_stage.sv
// ----------------------------------------------------------------------------
// cft_out_stage
// Result register between the step logic and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module cft_out_stage
    import cft_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_ready,
    output logic         o_can_load,
    output logic         o_valid,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

endmodule

`default_nettype wire

// File: hw/rtl/csv_field_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Splits CSV text into field content words, field ends, record ends and errors.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while the output is free, and gives
// at most one result word per byte. The byte is held in the input register, and
// its result word is registered in the result register that drives the output.
// The field mode update is a small next-state table between the two registers,
// so a byte can follow in every cycle while the output is taken. A result word
// that is held on the output stalls the input, even for bytes that give no
// result. The first line is the header; a later line with another field count
// gives a count mismatch error, and any error halts the block until reset.
`default_nettype none

module csv_field_tokenizer
    import cft_pkg::*;
#(
    parameter int unsigned MAX_FIELDS = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [55:0]      o_m_axis_tdata,   // [7:0] content_byte, [15:8] field_number,
                                               // [16] is_header, [48:17] line_number,
                                               // [50:49] error_code, [55:51] zero
    output logic [1:0]       o_m_axis_tuser    // [1:0] out_kind
);

    localparam int unsigned FIELD_CAP = (MAX_FIELDS < 255) ? MAX_FIELDS : 255;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out_res;
    logic       w_can_load;
    logic       w_adv;

    assign w_adv           = r_in_valid && w_can_load;
    assign o_s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode           <= MODE_EMPTY;
            r_state.header_pending <= 1'b1;
            r_state.header_fields  <= 8'd0;
            r_state.field_count    <= 8'd0;
            r_state.newlines_seen  <= 32'd0;
            r_state.halted         <= 1'b0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    cft_step #(
        .FIELD_CAP (FIELD_CAP)
    ) u_step (
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .o_state     (n_state),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    cft_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_adv && w_res_valid),
        .i_res      (w_res),
        .i_ready    (i_m_axis_tready),
        .o_can_load (w_can_load),
        .o_valid    (o_m_axis_tvalid),
        .o_res      (w_out_res)
    );

    assign o_m_axis_tdata = {5'd0, w_out_res.error_code, w_out_res.line_number,
                             w_out_res.is_header, w_out_res.field_number,
                             w_out_res.content_byte};
    assign o_m_axis_tuser = w_out_res.kind;

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CSV field tokenizer.
// ----------------------------------------------------------------------------
// A queue of text bytes feeds a stream driver. The bytes are a short fixed
// header and data line, then random three-field records, and then one broken
// sequence that halts the block, followed by bytes that must be dropped.
// Each accepted byte runs through a local tokenizer model whose result words
// wait in order. The monitor compares every output word with the oldest one,
// field by field. Both sides stall at random, the receiver holds off once for a
// long stretch, and the sender pauses once until the output has drained.

module tb;
    import cft_pkg::*;

    localparam int unsigned TEXT_TARGET = 1400;
    localparam int unsigned CALM_TAIL   = 150;
    localparam int unsigned HOLD_AT     = 400;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [7:0]  FIELD_CAP   = 8'd255;

    typedef struct packed {
        logic [7:0] data;
        logic       pause;
    } t_feed;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tready;
    logic        m_tvalid;
    logic        rx_ready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    t_feed       feed_queue[$];
    t_result     expected_words[$];

    int unsigned queued_words = 0;
    int unsigned text_words = 0;
    int unsigned fed_count = 0;
    int unsigned calm_from = '1;
    int unsigned cycle_count = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          word_taken = 1'b0;
    bit          failed = 1'b0;

    // tokenizer state
    logic [MODE_W-1:0] tok_mode;
    logic              hdr_pending;
    logic [7:0]        hdr_fields;
    logic [7:0]        fld_count;
    logic [31:0]       nl_seen;
    logic              tok_halted;

    csv_field_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),     // [7:0] data_byte
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (rx_ready),
        .o_m_axis_tdata  (m_tdata),     // [7:0] content_byte, [15:8] field_number,
                                        // [16] is_header, [48:17] line_number,
                                        // [50:49] error_code, [55:51] zero
        .o_m_axis_tuser  (m_tuser)      // [1:0] out_kind
    );

    always #5 i_clk = ~i_clk;

    function automatic bit tokenize_byte(input logic [7:0] b, output t_result r);
        logic [MODE_W-1:0] m;
        logic              is_nl;
        logic              sep;
        logic              quoted;
        logic [7:0]        next_count;
        r = '0;
        is_nl = (b == CHR_NEWLINE);
        sep = (b == CHR_COMMA) || is_nl;
        if (tok_halted)
            return 1'b0;
        if (b < CHR_SPACE && !is_nl)
            return 1'b0;
        m = (tok_mode > MODE_CLOSED) ? MODE_EMPTY : tok_mode;
        quoted = (m == MODE_QUOTED) || (m == MODE_QUOTED_ESC);
        r.field_number = fld_count;
        r.is_header = hdr_pending;
        r.line_number = (nl_seen == LINE_MAX) ? LINE_MAX : nl_seen + 32'd1;
        if (is_nl && nl_seen != LINE_MAX)
            nl_seen = nl_seen + 32'd1;

        if (m == MODE_CLOSED && !sep) begin
            tok_halted = 1'b1;
            r.kind = KIND_ERROR;
            r.error_code = (b == CHR_BACKSLASH) ? ERR_BACKSLASH :
                           (b == CHR_QUOTE) ? ERR_QUOTE : ERR_TEXT;
            return 1'b1;
        end
        if (m == MODE_PLAIN_ESC || m == MODE_QUOTED_ESC) begin
            tok_mode = (m == MODE_PLAIN_ESC) ? MODE_PLAIN : MODE_QUOTED;
            r.kind = KIND_CONTENT;
            r.content_byte = b;
            return 1'b1;
        end
        if (b == CHR_BACKSLASH) begin
            tok_mode = quoted ? MODE_QUOTED_ESC : MODE_PLAIN_ESC;
            return 1'b0;
        end
        if (b == CHR_QUOTE) begin
            if (m == MODE_EMPTY) begin
                tok_mode = MODE_QUOTED;
                return 1'b0;
            end
            if (m == MODE_QUOTED) begin
                tok_mode = MODE_CLOSED;
                return 1'b0;
            end
            tok_mode = MODE_PLAIN;
            r.kind = KIND_CONTENT;
            r.content_byte = b;
            return 1'b1;
        end
        if (sep && !quoted) begin
            next_count = (fld_count >= FIELD_CAP) ? FIELD_CAP : fld_count + 8'd1;
            tok_mode = MODE_EMPTY;
            if (!is_nl) begin
                fld_count = next_count;
                r.kind = KIND_FIELD_END;
                return 1'b1;
            end
            if (hdr_pending) begin
                hdr_fields = next_count;
                hdr_pending = 1'b0;
            end else if (next_count != hdr_fields) begin
                tok_halted = 1'b1;
                fld_count = next_count;
                r.kind = KIND_ERROR;
                r.error_code = ERR_COUNT;
                return 1'b1;
            end
            fld_count = 8'd0;
            r.kind = KIND_RECORD_END;
            return 1'b1;
        end
        tok_mode = quoted ? MODE_QUOTED : MODE_PLAIN;
        r.kind = KIND_CONTENT;
        r.content_byte = b;
        return 1'b1;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        t_feed item;
        item.data = b;
        item.pause = 1'b0;
        feed_queue.push_back(item);
        queued_words++;
        if (b >= CHR_SPACE || b == CHR_NEWLINE)
            text_words++;
    endtask

    task automatic push_pause();
        t_feed item;
        item.data = 8'h00;
        item.pause = 1'b1;
        feed_queue.push_back(item);
    endtask

    // sprinkle dropped control bytes into the text
    task automatic push_text(input logic [7:0] b);
        logic [7:0] ctl;
        if ($urandom_range(0, 29) == 0) begin
            ctl = 8'($urandom_range(0, 30));
            if (ctl >= CHR_NEWLINE)
                ctl = ctl + 8'd1;
            push_byte(ctl);
        end
        push_byte(b);
    endtask

    function automatic logic [7:0] pick_escaped();
        case ($urandom_range(0, 7))
            0: return CHR_COMMA;
            1: return CHR_NEWLINE;
            2: return CHR_QUOTE;
            3: return CHR_BACKSLASH;
            default: return 8'($urandom_range(32, 255));
        endcase
    endfunction

    task automatic emit_plain(input int unsigned len);
        int unsigned roll;
        logic [7:0]  c;
        for (int unsigned i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                push_text(CHR_BACKSLASH);
                push_text(pick_escaped());
            end else if (roll < 16 && i != 0) begin
                push_text(CHR_QUOTE);
            end else begin
                c = 8'($urandom_range(32, 255));
                if (c == CHR_COMMA || c == CHR_QUOTE || c == CHR_BACKSLASH)
                    c = "x";
                push_text(c);
            end
        end
    endtask

    task automatic emit_quoted(input int unsigned len);
        int unsigned roll;
        logic [7:0]  c;
        push_text(CHR_QUOTE);
        for (int unsigned i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                push_text(CHR_BACKSLASH);
                push_text(pick_escaped());
            end else if (roll < 20) begin
                push_text(CHR_NEWLINE);
            end else if (roll < 30) begin
                push_text(CHR_COMMA);
            end else begin
                c = 8'($urandom_range(32, 255));
                if (c == CHR_QUOTE || c == CHR_BACKSLASH)
                    c = "y";
                push_text(c);
            end
        end
        push_text(CHR_QUOTE);
    endtask

    task automatic emit_record(input int unsigned fields, input bit sparse);
        int unsigned roll;
        for (int unsigned i = 0; i < fields; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < (sparse ? 90 : 15))
                ;
            else if (roll < (sparse ? 95 : 60))
                emit_plain($urandom_range(1, 6));
            else
                emit_quoted($urandom_range(0, 6));
            if (i != fields - 1)
                push_text(CHR_COMMA);
        end
        push_text(CHR_NEWLINE);
    endtask

    // one broken sequence at the start of a record; the block halts on it
    task automatic emit_break();
        logic [1:0]  pick;
        logic [7:0]  c;
        int unsigned fields;
        pick = 2'($urandom_range(0, 3));
        if (pick != ERR_COUNT) begin
            push_text(CHR_QUOTE);
            push_text("z");
            push_text(CHR_QUOTE);
        end
        case (pick)
            ERR_BACKSLASH: push_text(CHR_BACKSLASH);
            ERR_QUOTE:     push_text(CHR_QUOTE);
            ERR_TEXT: begin
                c = 8'($urandom_range(32, 255));
                if (c == CHR_COMMA || c == CHR_QUOTE || c == CHR_BACKSLASH)
                    c = 8'hFE;
                push_text(c);
            end
            default: begin
                if ($urandom_range(0, 2) == 0) begin
                    emit_record($urandom_range(256, 300), 1'b1);
                end else begin
                    fields = $urandom_range(1, 5);
                    if (fields >= 3)
                        fields++;
                    emit_record(fields, 1'b0);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            failed = 1'b1;
        end
    endtask

    // check result words, then record and predict the accepted byte
    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            if (i_rst_n && m_tvalid && rx_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: kind %0d data 0x%0h", m_tuser, m_tdata);
                    failed = 1'b1;
                end else begin
                    want = expected_words.pop_front();
                    check_field("out_kind", 32'(want.kind), 32'(m_tuser));
                    check_field("content_byte", 32'(want.content_byte), 32'(m_tdata[7:0]));
                    check_field("field_number", 32'(want.field_number), 32'(m_tdata[15:8]));
                    check_field("is_header", 32'(want.is_header), 32'(m_tdata[16]));
                    check_field("line_number", want.line_number, m_tdata[48:17]);
                    check_field("error_code", 32'(want.error_code), 32'(m_tdata[50:49]));
                    check_field("tdata padding", 32'd0, 32'(m_tdata[55:51]));
                end
            end
            word_taken = i_rst_n && s_tvalid && s_tready;
            if (word_taken) begin
                fed_count++;
                if (tokenize_byte(s_tdata, got))
                    expected_words.push_back(got);
            end
        end
    end

    always @(negedge i_clk) begin : driver
        logic  nxt_valid;
        logic [7:0] nxt_data;
        t_feed item;
        nxt_valid = s_tvalid;
        nxt_data = s_tdata;
        if (i_rst_n && (!s_tvalid || word_taken)) begin
            nxt_valid = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (feed_queue.size() != 0) begin
                if (feed_queue[0].pause) begin
                    if (expected_words.size() == 0)
                        item = feed_queue.pop_front();
                end else if (fed_count < calm_from && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 2);
                end else begin
                    item = feed_queue.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data = item.data;
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata <= nxt_data;
    end

    always @(negedge i_clk) begin : receiver
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (hold_left != 0) begin
            hold_left--;
            nxt_ready = 1'b0;
            if (hold_left == 0)
                hold_done = 1'b1;
        end else if (!hold_done && fed_count >= HOLD_AT) begin
            hold_left = HOLD_CYCLES - 1;
            nxt_ready = 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            nxt_ready = 1'b0;
        end else if (fed_count < calm_from && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            nxt_ready = 1'b0;
        end
        rx_ready <= nxt_ready;
    end

    initial begin
        bit paused;
        paused = 1'b0;
        tok_mode = MODE_EMPTY;
        hdr_pending = 1'b1;
        hdr_fields = 8'd0;
        fld_count = 8'd0;
        nl_seen = 32'd0;
        tok_halted = 1'b0;

        // header: quoted field holding a comma, a newline and an escaped quote
        push_byte(CHR_QUOTE);
        push_byte("a");
        push_byte(CHR_COMMA);
        push_byte(CHR_NEWLINE);
        push_byte(CHR_BACKSLASH);
        push_byte(CHR_QUOTE);
        push_byte(CHR_QUOTE);
        push_byte(CHR_COMMA);
        // plain field with a bare quote, a dropped control byte, an escaped newline
        push_byte("b");
        push_byte(CHR_QUOTE);
        push_byte(8'h01);
        push_byte(CHR_BACKSLASH);
        push_byte(CHR_NEWLINE);
        push_byte(CHR_COMMA);
        push_byte(CHR_NEWLINE);
        // data line: high bytes, an empty field, DEL, NUL and a space
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(CHR_COMMA);
        push_byte(CHR_COMMA);
        push_byte(8'h7F);
        push_byte(8'h00);
        push_byte(CHR_SPACE);
        push_byte(CHR_NEWLINE);

        while (text_words < TEXT_TARGET - 40) begin
            emit_record(3, 1'b0);
            if (!paused && text_words >= TEXT_TARGET / 2) begin
                push_pause();
                paused = 1'b1;
            end
        end
        emit_break();
        for (int i = 0; i < 30; i++)
            push_byte(8'($urandom_range(0, 255)));
        calm_from = queued_words - CALM_TAIL;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_queue.size() != 0 || s_tvalid)
            @(posedge i_clk);
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (expected_words.size() != 0) begin
            $error("%0d result words never arrived", expected_words.size());
            failed = 1'b1;
        end
        if (failed)
            $display("Some tests failed");
        else
            $display("All tests passed");
        $finish;
    end

endmodule
